// File: rtl/aso_pkg.sv
// ============================================================================
// aso_pkg
// Shared types, codes and helpers of the ARM shifter operand unit.
// ============================================================================
package aso_pkg;

   localparam int unsigned DataWidth = 32;
   localparam int unsigned AmtWidth  = 5;

   // Shift type field, instruction bits 6..5
   localparam logic [1:0] SHIFT_LSL = 2'd0;
   localparam logic [1:0] SHIFT_LSR = 2'd1;
   localparam logic [1:0] SHIFT_ASR = 2'd2;
   localparam logic [1:0] SHIFT_ROR = 2'd3;

   // Keep-mask kinds applied after the rotate
   localparam logic [1:0] KEEP_ALL  = 2'd0;
   localparam logic [1:0] KEEP_NONE = 2'd1;
   localparam logic [1:0] KEEP_LOW  = 2'd2;   // clear the low amt bits
   localparam logic [1:0] KEEP_HIGH = 2'd3;   // clear the high amt bits

   localparam logic [DataWidth-1:0] ALL_ONES = 32'hffff_ffff;

   typedef struct packed {
      logic [DataWidth-1:0] src;
      logic [AmtWidth-1:0]  rot;
      logic [1:0]           kind;
      logic [AmtWidth-1:0]  amt;
      logic                 fill;
      logic                 carry_rot;   // carry is taken from the rotated value: bit 31, or bit 0 with carry_low
      logic                 carry_low;   // carry is bit 0 of the rotated value
      logic                 carry_fix;
      logic                 sbit;
      logic                 legal;
   } dec_type;

   function automatic logic [DataWidth-1:0] rotr(input logic [DataWidth-1:0] v,
                                                 input logic [AmtWidth-1:0] r);
      logic [2*DataWidth-1:0] dbl;
      dbl = {v, v} >> r;
      return dbl[DataWidth-1:0];
   endfunction

   function automatic logic [DataWidth-1:0] keep_mask(input logic [1:0] kind,
                                                      input logic [AmtWidth-1:0] amt);
      logic [DataWidth-1:0] m;
      case (kind)
         KEEP_ALL:  m = ALL_ONES;
         KEEP_NONE: m = '0;
         KEEP_LOW:  m = ALL_ONES << amt;
         default:   m = ALL_ONES >> amt;
      endcase
      return m;
   endfunction

endpackage

// File: rtl/aso_decode.sv
// ============================================================================
// aso_decode
// Decodes the operand form and reduces every shift to a rotate, a keep mask,
// a fill bit and a carry source.
// ============================================================================
module aso_decode import aso_pkg::*; (
   input  logic [31:0] instr_word,
   input  logic [31:0] rm_value,
   input  logic [31:0] rs_value,
   input  logic        carry_in,
   output dec_type     dec
);

   logic [1:0]          stype;
   logic [7:0]          sreg;
   logic                sreg_big;
   logic                sreg_32;
   logic [AmtWidth-1:0] simm;

   assign stype    = instr_word[6:5];
   assign sreg     = rs_value[7:0];
   assign sreg_big = |sreg[7:5];
   assign sreg_32  = (sreg == 8'd32);
   assign simm     = instr_word[11:7];

   always_comb begin
      dec           = '0;
      dec.src       = rm_value;
      dec.kind      = KEEP_ALL;
      dec.carry_fix = carry_in;
      dec.sbit      = instr_word[20];
      dec.legal     = 1'b1;
      if (instr_word[25]) begin
         dec.src       = {24'd0, instr_word[7:0]};
         dec.rot       = {instr_word[11:8], 1'b0};
         dec.carry_rot = (instr_word[11:8] != 4'd0);
      end else if (instr_word[4] && instr_word[7]) begin
         dec.legal = 1'b0;
         dec.sbit  = 1'b0;
         dec.kind  = KEEP_NONE;
      end else if (instr_word[4]) begin
         if (sreg != 8'd0) begin
            unique case (stype)
               SHIFT_LSL: begin
                  if (!sreg_big) begin
                     dec.rot       = AmtWidth'(5'd0 - sreg[4:0]);
                     dec.kind      = KEEP_LOW;
                     dec.amt       = sreg[4:0];
                     dec.carry_rot = 1'b1;
                     dec.carry_low = 1'b1;
                  end else begin
                     dec.kind      = KEEP_NONE;
                     dec.carry_fix = sreg_32 & rm_value[0];
                  end
               end
               SHIFT_LSR: begin
                  if (!sreg_big) begin
                     dec.rot       = sreg[4:0];
                     dec.kind      = KEEP_HIGH;
                     dec.amt       = sreg[4:0];
                     dec.carry_rot = 1'b1;
                  end else begin
                     dec.kind      = KEEP_NONE;
                     dec.carry_fix = sreg_32 & rm_value[31];
                  end
               end
               SHIFT_ASR: begin
                  dec.fill = rm_value[31];
                  if (!sreg_big) begin
                     dec.rot       = sreg[4:0];
                     dec.kind      = KEEP_HIGH;
                     dec.amt       = sreg[4:0];
                     dec.carry_rot = 1'b1;
                  end else begin
                     dec.kind      = KEEP_NONE;
                     dec.carry_fix = rm_value[31];
                  end
               end
               default: begin
                  dec.rot       = sreg[4:0];
                  dec.carry_rot = 1'b1;
               end
            endcase
         end
      end else begin
         if (simm != '0) begin
            dec.carry_rot = 1'b1;
            unique case (stype)
               SHIFT_LSL: begin
                  dec.rot       = AmtWidth'(5'd0 - simm);
                  dec.kind      = KEEP_LOW;
                  dec.amt       = simm;
                  dec.carry_low = 1'b1;
               end
               SHIFT_LSR: begin
                  dec.rot  = simm;
                  dec.kind = KEEP_HIGH;
                  dec.amt  = simm;
               end
               SHIFT_ASR: begin
                  dec.rot  = simm;
                  dec.kind = KEEP_HIGH;
                  dec.amt  = simm;
                  dec.fill = rm_value[31];
               end
               default: begin
                  dec.rot = simm;
               end
            endcase
         end else begin
            unique case (stype)
               SHIFT_LSL: begin
                  dec.kind = KEEP_ALL;
               end
               SHIFT_LSR: begin
                  dec.kind      = KEEP_NONE;
                  dec.carry_fix = rm_value[31];
               end
               SHIFT_ASR: begin
                  dec.kind      = KEEP_NONE;
                  dec.fill      = rm_value[31];
                  dec.carry_fix = rm_value[31];
               end
               default: begin
                  // rotate right through carry
                  dec.rot       = AmtWidth'(1);
                  dec.kind      = KEEP_HIGH;
                  dec.amt       = AmtWidth'(1);
                  dec.fill      = carry_in;
                  dec.carry_rot = 1'b1;
               end
            endcase
         end
      end
   end

endmodule

// File: rtl/arm_shifter_operand_unit_core.sv
// ============================================================================
// arm_shifter_operand_unit_core
// Second operand and shifter carry of ARM data-processing instructions.
// ============================================================================
// Takes one request per cycle while the result side does not stall. The
// three register stages are: decode of the operand form into a rotate
// amount, keep mask kind and carry source; the 32-bit barrel rotate together
// with the keep mask; and the final merge of rotated value, mask and fill
// bit into the output register. Each stage holds on its own, so a waiting
// result does not block new requests until the pipeline is full.
// ============================================================================
module arm_shifter_operand_unit_core import aso_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // instr_word[31:0], rm_value[63:32], rs_value[95:64], carry_in[96], zero pad
   input  logic [103:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // operand_value[31:0], carry_out[32], carry_write[33], is_legal[34], zero pad
   output logic [39:0]  rsp_tdata
);

   dec_type dec;

   logic    s1_valid_ff, s1_valid_in;
   dec_type s1_ff;
   logic    s1_ready;

   logic                 s2_valid_ff, s2_valid_in;
   logic [DataWidth-1:0] s2_rot_ff, s2_keep_ff;
   logic                 s2_fill_ff, s2_carry_rot_ff, s2_carry_low_ff, s2_carry_fix_ff;
   logic                 s2_sbit_ff, s2_legal_ff;
   logic                 s2_ready;

   logic                 s3_valid_ff, s3_valid_in;
   logic [DataWidth-1:0] s3_value_ff, s3_value_in;
   logic                 s3_carry_ff, s3_carry_in;
   logic                 s3_sbit_ff, s3_legal_ff;
   logic                 s3_ready;

   aso_decode u_decode (
      .instr_word (req_tdata[31:0]),
      .rm_value   (req_tdata[63:32]),
      .rs_value   (req_tdata[95:64]),
      .carry_in   (req_tdata[96]),
      .dec        (dec)
   );

   assign s3_ready   = !s3_valid_ff || rsp_tready;
   assign s2_ready   = !s2_valid_ff || s3_ready;
   assign s1_ready   = !s1_valid_ff || s2_ready;
   assign req_tready = s1_ready;

   assign s1_valid_in = s1_ready ? req_tvalid : s1_valid_ff;
   assign s2_valid_in = s2_ready ? s1_valid_ff : s2_valid_ff;
   assign s3_valid_in = s3_ready ? s2_valid_ff : s3_valid_ff;

   assign s3_value_in = (s2_rot_ff & s2_keep_ff) | ({DataWidth{s2_fill_ff}} & ~s2_keep_ff);
   assign s3_carry_in = !s2_carry_rot_ff ? s2_carry_fix_ff :
                        s2_carry_low_ff  ? s2_rot_ff[0] : s2_rot_ff[DataWidth-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_ff <= dec;
      end
      if (s2_ready) begin
         s2_rot_ff       <= rotr(s1_ff.src, s1_ff.rot);
         s2_keep_ff      <= keep_mask(s1_ff.kind, s1_ff.amt);
         s2_fill_ff      <= s1_ff.fill;
         s2_carry_rot_ff <= s1_ff.carry_rot;
         s2_carry_low_ff <= s1_ff.carry_low;
         s2_carry_fix_ff <= s1_ff.carry_fix;
         s2_sbit_ff      <= s1_ff.sbit;
         s2_legal_ff     <= s1_ff.legal;
      end
      if (s3_ready) begin
         s3_value_ff <= s3_value_in;
         s3_carry_ff <= s3_carry_in;
         s3_sbit_ff  <= s2_sbit_ff;
         s3_legal_ff <= s2_legal_ff;
      end
   end

   assign rsp_tvalid = s3_valid_ff;
   assign rsp_tdata  = {5'd0, s3_legal_ff, s3_sbit_ff, s3_carry_ff, s3_value_ff};

   // drop the flag update and the operand on an illegal register shift
   a_illegal_clean: assert property (@(posedge clock) disable iff (reset)
      (s3_valid_ff && !s3_legal_ff) |-> (s3_value_ff == '0 && !s3_sbit_ff))
      else $error("illegal request left operand or flag update set");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> s1_valid_ff)
      else $error("accepted request did not enter the decode stage");

   a_stage2_hold: assert property (@(posedge clock) disable iff (reset)
      (s3_valid_ff && !rsp_tready && s2_valid_ff) |=> s2_valid_ff)
      else $error("rotate stage lost a request during a stall");

   a_stage1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s2_ready) |=> (s1_valid_ff && $stable(s1_ff)))
      else $error("decode stage changed during a stall");

endmodule
